>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

>>> hw/rtl/wcc_pkg.sv
// ---------------------------------------------------------------------------
// wcc_pkg
// Types and constants of the weak component counter.
// ---------------------------------------------------------------------------
`default_nettype none

package wcc_pkg;

	localparam int MAX_ARTICLES_DEF = 64;
	localparam int IDX_W            = 6;
	localparam int CNT_W            = 7;
	localparam logic [CNT_W-1:0] COUNT_LIMIT = 7'd127;

	typedef enum logic [1:0] {
		ACT_ADD_ARTICLE  = 2'd0,
		ACT_ADD_CITATION = 2'd1,
		ACT_REMOVE       = 2'd2,
		ACT_UNUSED       = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [IDX_W-1:0] first_article;
		logic [IDX_W-1:0] second_article;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] group_count;
		logic             removed_was_present;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CIT_RD_A,
		ST_CIT_WR_A,
		ST_CIT_RD_B,
		ST_CIT_WR_B,
		ST_RM_SWEEP,
		ST_RM_DRAIN,
		ST_SEEK,
		ST_WALK_RD,
		ST_WALK_UPD,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/wcc_adj_mem.sv
// ---------------------------------------------------------------------------
// wcc_adj_mem
// Undirected adjacency rows, one read and one write port, registered read.
// Rows never written read as zero through per-row valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module wcc_adj_mem #(
	parameter int ROWS = 64,
	parameter int AW   = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output logic      [ROWS-1:0] rd_data,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire logic [ROWS-1:0] wr_data
);

	logic [ROWS-1:0] mem [ROWS];
	logic [ROWS-1:0] row_q;
	logic [ROWS-1:0] valid_q;
	logic            row_ok_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			row_q <= mem[rd_addr];
		end
	end

	// row valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			row_ok_q <= 1'b0;
		end else begin
			if (rd_en) begin
				row_ok_q <= valid_q[rd_addr];
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = row_ok_q ? row_q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/wcc_pick.sv
// ---------------------------------------------------------------------------
// wcc_pick
// Lowest set bit of a vector: flag, one-hot mask and index.
// ---------------------------------------------------------------------------
`default_nettype none

module wcc_pick #(
	parameter int W  = 64,
	parameter int AW = 6
) (
	input  wire logic [W-1:0]  vec,
	output logic               any,
	output logic [W-1:0]       onehot,
	output logic [AW-1:0]      idx
);

	// isolate lowest set bit, then encode
	always_comb begin
		onehot = vec & (~vec + W'(1));
		any    = |vec;
		idx    = '0;
		for (int i = 0; i < W; i++) begin
			if (onehot[i]) begin
				idx = idx | AW'(i);
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/weak_component_count_after_removal.sv
// ---------------------------------------------------------------------------
// weak_component_count_after_removal
// Citation graph store with article removal and weak group count.
// ---------------------------------------------------------------------------
//  channel | signals                   | transfer when
//  cmd     | cmd_valid cmd_stall cmd   | cmd_valid & !cmd_stall
//  res     | res_valid res_stall res   | res_valid & !res_stall
//
//  Add article updates the present set only. Add citation: two read-modify-writes,
//  row A then row B. Remove: if the article was present, a sweep reads every row
//  and writes it back without the article; then each remaining group is walked,
//  each of its rows read once, and a final empty search leads to posting the
//  result; the single read port of the adjacency memory serializes these reads.
//  Reset clears the store through per-row valid bits; no clearing pass.
//  A pending result does not block new commands; only posting the next one
//  waits for res_stall to drop.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module weak_component_count_after_removal #(
	parameter int MAX_ARTICLES = wcc_pkg::MAX_ARTICLES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire wcc_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_stall,
	output wcc_pkg::res_t      res
);

	// only indices reachable by the 6-bit fields get rows
	localparam int ROWS = (MAX_ARTICLES < 64) ? MAX_ARTICLES : 64;
	localparam int AW   = $clog2(ROWS);
	localparam logic [ROWS-1:0] ONE = ROWS'(1);

	wcc_pkg::state_t state_q, state_d;

	logic [ROWS-1:0]          present_q, visited_q, frontier_q;
	logic [AW-1:0]            a_q, b_q, sweep_q, sw_addr_s1;
	logic                     sw_valid_s1;
	logic                     was_q;
	logic [wcc_pkg::CNT_W-1:0] count_q;
	logic                     res_valid_q;
	wcc_pkg::res_t            res_q;

	logic                     rd_en, wr_en;
	logic [AW-1:0]            rd_addr, wr_addr;
	logic [ROWS-1:0]          rd_data, wr_data;

	logic                     cmd_xfer, a_ok, b_ok;
	logic [ROWS-1:0]          cand, nb;
	logic                     cand_any, fr_any;
	logic [ROWS-1:0]          cand_oh, fr_oh;
	logic [AW-1:0]            cand_idx, fr_idx;
	logic                     post_ok;

	assign cmd_xfer = cmd_valid && !cmd_stall;
	assign a_ok     = 7'(cmd.first_article) < 7'(ROWS);
	assign b_ok     = 7'(cmd.second_article) < 7'(ROWS);
	assign cand     = present_q & ~visited_q;
	assign nb       = rd_data & present_q & ~visited_q;
	assign post_ok  = !res_valid_q || !res_stall;

	wcc_adj_mem #(.ROWS(ROWS), .AW(AW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	wcc_pick #(.W(ROWS), .AW(AW)) u_pick_seed (
		.vec    (cand),
		.any    (cand_any),
		.onehot (cand_oh),
		.idx    (cand_idx)
	);

	wcc_pick #(.W(ROWS), .AW(AW)) u_pick_front (
		.vec    (frontier_q),
		.any    (fr_any),
		.onehot (fr_oh),
		.idx    (fr_idx)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control; the sequencer never overlaps a
	// read and a write of the same row, so no forwarding is needed
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = a_q;
		wr_en   = 1'b0;
		wr_addr = a_q;
		wr_data = rd_data;
		unique case (state_q)
			wcc_pkg::ST_IDLE: begin
				if (cmd_xfer) begin
					priority case (wcc_pkg::action_t'(cmd.action))
						wcc_pkg::ACT_ADD_CITATION: begin
							if (a_ok && b_ok) state_d = wcc_pkg::ST_CIT_RD_A;
						end
						wcc_pkg::ACT_REMOVE: begin
							if (a_ok && present_q[cmd.first_article[AW-1:0]]) begin
								state_d = wcc_pkg::ST_RM_SWEEP;
							end else begin
								state_d = wcc_pkg::ST_SEEK;
							end
						end
						default: state_d = wcc_pkg::ST_IDLE;
					endcase
				end
			end
			wcc_pkg::ST_CIT_RD_A: begin
				rd_en   = 1'b1;
				rd_addr = a_q;
				state_d = wcc_pkg::ST_CIT_WR_A;
			end
			wcc_pkg::ST_CIT_WR_A: begin
				wr_en   = 1'b1;
				wr_addr = a_q;
				wr_data = rd_data | (ONE << b_q);
				state_d = wcc_pkg::ST_CIT_RD_B;
			end
			wcc_pkg::ST_CIT_RD_B: begin
				rd_en   = 1'b1;
				rd_addr = b_q;
				state_d = wcc_pkg::ST_CIT_WR_B;
			end
			wcc_pkg::ST_CIT_WR_B: begin
				wr_en   = 1'b1;
				wr_addr = b_q;
				wr_data = rd_data | (ONE << a_q);
				state_d = wcc_pkg::ST_IDLE;
			end
			wcc_pkg::ST_RM_SWEEP, wcc_pkg::ST_RM_DRAIN: begin
				// read row sweep_q, write back the row read in the previous cycle
				rd_en   = (state_q == wcc_pkg::ST_RM_SWEEP);
				rd_addr = sweep_q;
				wr_en   = sw_valid_s1;
				wr_addr = sw_addr_s1;
				wr_data = (sw_addr_s1 == a_q) ? '0 : (rd_data & ~(ONE << a_q));
				if (state_q == wcc_pkg::ST_RM_DRAIN) begin
					state_d = wcc_pkg::ST_SEEK;
				end else if (sweep_q == AW'(ROWS - 1)) begin
					state_d = wcc_pkg::ST_RM_DRAIN;
				end
			end
			wcc_pkg::ST_SEEK: begin
				// start a new group at the lowest unvisited article
				rd_en   = cand_any;
				rd_addr = cand_idx;
				state_d = cand_any ? wcc_pkg::ST_WALK_UPD : wcc_pkg::ST_FINISH;
			end
			wcc_pkg::ST_WALK_RD: begin
				rd_en   = fr_any;
				rd_addr = fr_idx;
				state_d = fr_any ? wcc_pkg::ST_WALK_UPD : wcc_pkg::ST_SEEK;
			end
			wcc_pkg::ST_WALK_UPD: begin
				state_d = wcc_pkg::ST_WALK_RD;
			end
			wcc_pkg::ST_FINISH: begin
				if (post_ok) state_d = wcc_pkg::ST_IDLE;
			end
			default: state_d = wcc_pkg::ST_IDLE;
		endcase
	end

	assign cmd_stall = (state_q != wcc_pkg::ST_IDLE);

	// control registers: present set, walk sets, sweep pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			visited_q   <= '0;
			frontier_q  <= '0;
			sweep_q     <= '0;
			sw_valid_s1 <= 1'b0;
			count_q     <= '0;
			was_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			sw_valid_s1 <= (state_q == wcc_pkg::ST_RM_SWEEP);
			// result valid: set when a count is posted, cleared on transfer
			if (state_q == wcc_pkg::ST_FINISH && post_ok) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				wcc_pkg::ST_IDLE: begin
					if (cmd_xfer) begin
						priority case (wcc_pkg::action_t'(cmd.action))
							wcc_pkg::ACT_ADD_ARTICLE: begin
								if (a_ok) present_q <= present_q
									| (ONE << cmd.first_article[AW-1:0]);
							end
							wcc_pkg::ACT_ADD_CITATION: begin
								if (a_ok && b_ok) present_q <= present_q
									| (ONE << cmd.first_article[AW-1:0])
									| (ONE << cmd.second_article[AW-1:0]);
							end
							wcc_pkg::ACT_REMOVE: begin
								visited_q  <= '0;
								frontier_q <= '0;
								count_q    <= '0;
								sweep_q    <= '0;
								if (a_ok && present_q[cmd.first_article[AW-1:0]]) begin
									was_q     <= 1'b1;
									present_q <= present_q
										& ~(ONE << cmd.first_article[AW-1:0]);
								end else begin
									was_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				wcc_pkg::ST_RM_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
				end
				wcc_pkg::ST_SEEK: begin
					if (cand_any) begin
						visited_q <= visited_q | cand_oh;
						if (count_q != wcc_pkg::COUNT_LIMIT) count_q <= count_q + 7'd1;
					end
				end
				wcc_pkg::ST_WALK_RD: begin
					frontier_q <= frontier_q & ~fr_oh;
				end
				wcc_pkg::ST_WALK_UPD: begin
					frontier_q <= frontier_q | nb;
					visited_q  <= visited_q | nb;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == wcc_pkg::ST_IDLE && cmd_xfer) begin
			a_q <= cmd.first_article[AW-1:0];
			b_q <= cmd.second_article[AW-1:0];
		end
		sw_addr_s1 <= sweep_q;
		if (state_q == wcc_pkg::ST_FINISH && post_ok) begin
			res_q.group_count         <= count_q;
			res_q.removed_was_present <= was_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	`ASSERT_IMPLY(a_front_in_visited, clk, arst_n, state_q == wcc_pkg::ST_WALK_RD, (frontier_q & ~visited_q) == '0)
	`ASSERT_IMPLY(a_seek_front_empty, clk, arst_n, state_q == wcc_pkg::ST_SEEK, frontier_q == '0)
	`ASSERT_IMPLY(a_res_from_finish, clk, arst_n, $rose(res_valid_q), $past(state_q) == wcc_pkg::ST_FINISH)
	`ASSERT_NEVER(a_no_write_in_walk, clk, arst_n, wr_en && (state_q == wcc_pkg::ST_SEEK || state_q == wcc_pkg::ST_WALK_RD || state_q == wcc_pkg::ST_WALK_UPD))

endmodule

`default_nettype wire
